// ===== rtl/afs_pkg.sv =====
package afs_pkg;

   // item kinds
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   // register offsets from the audio unit base
   localparam logic [4:0] OFS_STATUS = 5'h15;
   localparam logic [4:0] OFS_FRAME  = 5'h17;

   // frame counter write bits
   localparam int MODE_BIT    = 7;
   localparam int INHIBIT_BIT = 6;

   // reset delay codes
   localparam logic [1:0] DELAY_IDLE = 2'd0;
   localparam logic [1:0] DELAY_NOW  = 2'd1;
   localparam logic [1:0] DELAY_WAIT = 2'd2;

   // sequence points in cpu cycles
   localparam logic [15:0] CNT_RESET  = 16'd10;
   localparam logic [15:0] CNT_STEP1  = 16'd7459;
   localparam logic [15:0] CNT_STEP2  = 16'd14915;
   localparam logic [15:0] CNT_STEP3  = 16'd22373;
   localparam logic [15:0] CNT_IRQ_A  = 16'd29830;
   localparam logic [15:0] CNT_IRQ_B  = 16'd29831;
   localparam logic [15:0] CNT_IRQ_C  = 16'd29832;
   localparam logic [15:0] CNT_WRAP4  = 16'd37289;
   localparam logic [15:0] CNT_WRAP5  = 16'd37283;
   localparam logic [15:0] CNT_FIRST5 = 16'd1;

endpackage

// ===== rtl/afs_if.sv =====
interface afs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [4:0] reg_offset;
   logic [7:0] write_data;
   logic [4:0] channel_active;
   logic       dmc_irq;

   modport source (output valid, kind, reg_offset, write_data, channel_active, dmc_irq,
                   input ready);
   modport sink   (input valid, kind, reg_offset, write_data, channel_active, dmc_irq,
                   output ready);
endinterface

interface afs_rsp_if;
   logic       valid;
   logic       ready;
   logic       quarter_frame;
   logic       half_frame;
   logic       frame_irq;
   logic [7:0] read_data;
   logic       enable_update;
   logic [4:0] channel_enables;

   modport source (output valid, quarter_frame, half_frame, frame_irq, read_data,
                   enable_update, channel_enables, input ready);
   modport sink   (input valid, quarter_frame, half_frame, frame_irq, read_data,
                   enable_update, channel_enables, output ready);
endinterface

// ===== rtl/apu_frame_sequencer.sv =====
// each accepted request's response is registered into the output register
// throughput: one item per cycle while rsp_ch.ready holds; the output register frees as its transfer completes
// the whole sequencer step is one pass of compare/increment logic on the cycle counter
// reset: synchronous, active high; counter to 10, four-step mode, irq and inhibit clear,
// reset delay idle, output register empty; no request is taken while reset is high
module apu_frame_sequencer (
   input logic  clock,
   input logic  reset,
   afs_req_if.sink   req_ch,
   afs_rsp_if.source rsp_ch
);
   import afs_pkg::*;

   // sequencer state
   logic [15:0] cycle_count_ff, cycle_count_in;
   logic        five_step_ff, five_step_in;
   logic        irq_inhibit_ff, irq_inhibit_in;
   logic        irq_flag_ff, irq_flag_in;
   logic        odd_phase_ff, odd_phase_in;
   logic [1:0]  reset_delay_ff, reset_delay_in;
   logic        skip_first_ff, skip_first_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_quarter_ff, rsp_quarter_in;
   logic        rsp_half_ff, rsp_half_in;
   logic        rsp_irq_ff, rsp_irq_in;
   logic [7:0]  rsp_rdata_ff, rsp_rdata_in;
   logic        rsp_update_ff, rsp_update_in;
   logic [4:0]  rsp_enables_ff, rsp_enables_in;

   logic        accept;
   logic [15:0] count_eff;   // counter after a pending reset delay lands
   logic        raise_irq;

   // take a new request whenever the output register is empty or draining
   assign req_ch.ready = !reset && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      cycle_count_in = cycle_count_ff;
      five_step_in   = five_step_ff;
      irq_inhibit_in = irq_inhibit_ff;
      irq_flag_in    = irq_flag_ff;
      odd_phase_in   = odd_phase_ff;
      reset_delay_in = reset_delay_ff;
      skip_first_in  = skip_first_ff;
      rsp_quarter_in = 1'b0;
      rsp_half_in    = 1'b0;
      rsp_rdata_in   = 8'd0;
      rsp_update_in  = 1'b0;
      rsp_enables_in = 5'd0;
      raise_irq      = 1'b0;
      count_eff      = (reset_delay_ff == DELAY_NOW) ? 16'd0 : cycle_count_ff;

      case (req_ch.kind)
         KIND_TICK: begin
            // reset delay counts down first, then the phase flips
            case (reset_delay_ff)
               DELAY_WAIT: reset_delay_in = DELAY_NOW;
               DELAY_NOW:  reset_delay_in = DELAY_IDLE;
               default:    reset_delay_in = reset_delay_ff;
            endcase
            odd_phase_in   = !odd_phase_ff;
            cycle_count_in = count_eff + 16'd1;
            if (!five_step_ff) begin
               case (count_eff)
                  CNT_STEP1: rsp_quarter_in = 1'b1;
                  CNT_STEP2: begin
                     rsp_quarter_in = 1'b1;
                     rsp_half_in    = 1'b1;
                  end
                  CNT_STEP3: rsp_quarter_in = 1'b1;
                  CNT_IRQ_A: raise_irq = 1'b1;
                  CNT_IRQ_B: begin
                     rsp_quarter_in = 1'b1;
                     rsp_half_in    = 1'b1;
                     raise_irq      = 1'b1;
                  end
                  CNT_IRQ_C: raise_irq = 1'b1;
                  CNT_WRAP4: begin
                     // sequence restarts just past the first quarter point
                     rsp_quarter_in = 1'b1;
                     cycle_count_in = CNT_STEP1 + 16'd1;
                  end
                  default: ;
               endcase
            end else begin
               case (count_eff)
                  CNT_FIRST5: begin
                     // the clocks fired by the mode write stand in for this step
                     if (skip_first_ff) begin
                        skip_first_in = 1'b0;
                     end else begin
                        rsp_quarter_in = 1'b1;
                        rsp_half_in    = 1'b1;
                     end
                  end
                  CNT_STEP1: rsp_quarter_in = 1'b1;
                  CNT_STEP2: begin
                     rsp_quarter_in = 1'b1;
                     rsp_half_in    = 1'b1;
                  end
                  CNT_STEP3: rsp_quarter_in = 1'b1;
                  CNT_WRAP5: begin
                     rsp_quarter_in = 1'b1;
                     rsp_half_in    = 1'b1;
                     cycle_count_in = CNT_FIRST5 + 16'd1;
                  end
                  default: ;
               endcase
            end
            if (raise_irq && !irq_inhibit_ff) begin
               irq_flag_in = 1'b1;
            end
         end
         KIND_WRITE: begin
            if (req_ch.reg_offset == OFS_STATUS) begin
               rsp_update_in  = 1'b1;
               rsp_enables_in = req_ch.write_data[4:0];
            end else if (req_ch.reg_offset == OFS_FRAME) begin
               five_step_in   = req_ch.write_data[MODE_BIT];
               irq_inhibit_in = req_ch.write_data[INHIBIT_BIT];
               if (req_ch.write_data[MODE_BIT]) begin
                  rsp_quarter_in = 1'b1;
                  rsp_half_in    = 1'b1;
                  skip_first_in  = 1'b1;
               end
               if (req_ch.write_data[INHIBIT_BIT]) begin
                  irq_flag_in = 1'b0;
               end
               // restart lands one or two ticks later depending on cycle parity
               reset_delay_in = odd_phase_ff ? DELAY_WAIT : DELAY_NOW;
               cycle_count_in = 16'd0;
            end
         end
         KIND_READ: begin
            if (req_ch.reg_offset == OFS_STATUS) begin
               // status byte: dmc irq, frame irq, gap, channel activity
               rsp_rdata_in = {req_ch.dmc_irq, irq_flag_ff, 1'b0, req_ch.channel_active};
               irq_flag_in  = 1'b0;
            end
         end
         default: ;
      endcase
      rsp_irq_in = irq_flag_in;
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cycle_count_ff <= CNT_RESET;
         five_step_ff   <= 1'b0;
         irq_inhibit_ff <= 1'b0;
         irq_flag_ff    <= 1'b0;
         odd_phase_ff   <= 1'b0;
         reset_delay_ff <= DELAY_IDLE;
         skip_first_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            cycle_count_ff <= cycle_count_in;
            five_step_ff   <= five_step_in;
            irq_inhibit_ff <= irq_inhibit_in;
            irq_flag_ff    <= irq_flag_in;
            odd_phase_ff   <= odd_phase_in;
            reset_delay_ff <= reset_delay_in;
            skip_first_ff  <= skip_first_in;
         end
      end
   end

   // response payload, loaded with each accepted transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_quarter_ff <= rsp_quarter_in;
         rsp_half_ff    <= rsp_half_in;
         rsp_irq_ff     <= rsp_irq_in;
         rsp_rdata_ff   <= rsp_rdata_in;
         rsp_update_ff  <= rsp_update_in;
         rsp_enables_ff <= rsp_enables_in;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.quarter_frame   = rsp_quarter_ff;
   assign rsp_ch.half_frame      = rsp_half_ff;
   assign rsp_ch.frame_irq       = rsp_irq_ff;
   assign rsp_ch.read_data       = rsp_rdata_ff;
   assign rsp_ch.enable_update   = rsp_update_ff;
   assign rsp_ch.channel_enables = rsp_enables_ff;

endmodule

// ===== rtl/afs_checker.sv =====
module afs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_kind,
   input logic [4:0] req_reg_offset,
   input logic [7:0] req_write_data,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_quarter_frame,
   input logic       rsp_half_frame,
   input logic       rsp_frame_irq,
   input logic       rsp_enable_update,
   input logic [4:0] rsp_channel_enables
);
   import afs_pkg::*;

   logic req_xfer;
   logic frame_write;
   assign req_xfer    = req_valid && req_ready;
   assign frame_write = req_xfer && req_kind == KIND_WRITE && req_reg_offset == OFS_FRAME;

   // stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_half_frame)
         && $stable(rsp_quarter_frame) && $stable(rsp_channel_enables))
      else $error("stalled response changed");

   // status write shows its enables on the next response
   a_status_write: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_kind == KIND_WRITE && req_reg_offset == OFS_STATUS |=>
         rsp_valid && rsp_enable_update && rsp_channel_enables == $past(req_write_data[4:0]))
      else $error("status write response wrong");

   // five-step mode write fires both clocks at once
   a_mode_clocks: assert property (@(posedge clock) disable iff (reset)
      frame_write && req_write_data[MODE_BIT] |=> rsp_valid && rsp_quarter_frame
         && rsp_half_frame)
      else $error("mode write did not fire clocks");

   // inhibit write drops the frame interrupt
   a_inhibit: assert property (@(posedge clock) disable iff (reset)
      frame_write && req_write_data[INHIBIT_BIT] |=> rsp_valid && !rsp_frame_irq)
      else $error("inhibit did not clear frame irq");

   // a half-frame clock always comes with a quarter-frame clock
   a_half_quarter: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_half_frame |-> rsp_quarter_frame)
      else $error("half frame without quarter frame");

endmodule

bind apu_frame_sequencer afs_checker u_afs_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_ch.valid),
   .req_ready           (req_ch.ready),
   .req_kind            (req_ch.kind),
   .req_reg_offset      (req_ch.reg_offset),
   .req_write_data      (req_ch.write_data),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_quarter_frame   (rsp_ch.quarter_frame),
   .rsp_half_frame      (rsp_ch.half_frame),
   .rsp_frame_irq       (rsp_ch.frame_irq),
   .rsp_enable_update   (rsp_ch.enable_update),
   .rsp_channel_enables (rsp_ch.channel_enables)
);

// ===== test/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import afs_pkg::*;

   // kind code that the block leaves alone
   localparam logic [1:0] KIND_SPARE = 2'd3;

   // longest idle stretch either side may draw for one item
   localparam int MAX_WAIT = 12;

   // one pending request
   typedef struct {
      logic [1:0] kind;
      logic [4:0] reg_offset;
      logic [7:0] write_data;
      logic [4:0] channel_active;
      logic       dmc_irq;
   } req_item_type;

   // one expected response
   typedef struct {
      logic       quarter_frame;
      logic       half_frame;
      logic       frame_irq;
      logic [7:0] read_data;
      logic       enable_update;
      logic [4:0] channel_enables;
   } frame_result_type;

   // sequencer state as the predictor tracks it
   typedef struct {
      logic [15:0] count;
      logic        five_step;
      logic        inhibit;
      logic        irq_flag;
      logic        odd;
      logic [1:0]  delay;
      logic        skip_first;
   } seq_state_type;

   logic clock;
   logic reset;

   afs_req_if req_ch();
   afs_rsp_if rsp_ch();

   apu_frame_sequencer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   req_item_type     pending_q[$];
   frame_result_type frame_exp_q[$];
   seq_state_type    seq_st;

   int       mismatch_count;
   logic     req_taken;
   logic     rsp_taken;

   // driver bookkeeping, also watched by the end-of-run wait
   req_item_type drv_item;
   bit           drv_pending;
   bit           drv_hold;
   int           drv_gap;
   int           rsp_wait;

   // ------------------------------------------------------------------
   // predictor: advance the sequencer by one item, return its response
   // ------------------------------------------------------------------
   function automatic frame_result_type frame_step(input req_item_type it);
      frame_result_type res;
      logic             irq_hit;
      res = '{default: '0};
      irq_hit = 1'b0;
      case (it.kind)
         KIND_TICK: begin
            // pending restart delay acts before the sequence looks at the counter
            if (seq_st.delay == DELAY_WAIT) begin
               seq_st.delay = DELAY_NOW;
            end else if (seq_st.delay == DELAY_NOW) begin
               seq_st.count = '0;
               seq_st.delay = DELAY_IDLE;
            end
            seq_st.odd = ~seq_st.odd;
            if (!seq_st.five_step) begin
               case (seq_st.count)
                  CNT_STEP1: res.quarter_frame = 1'b1;
                  CNT_STEP2: begin
                     res.quarter_frame = 1'b1;
                     res.half_frame    = 1'b1;
                  end
                  CNT_STEP3: res.quarter_frame = 1'b1;
                  CNT_IRQ_A: irq_hit = 1'b1;
                  CNT_IRQ_B: begin
                     res.quarter_frame = 1'b1;
                     res.half_frame    = 1'b1;
                     irq_hit           = 1'b1;
                  end
                  CNT_IRQ_C: irq_hit = 1'b1;
                  CNT_WRAP4: begin
                     res.quarter_frame = 1'b1;
                     seq_st.count      = CNT_STEP1;
                  end
                  default: ;
               endcase
            end else begin
               case (seq_st.count)
                  CNT_FIRST5: begin
                     // first step after a five-step write is swallowed once
                     if (seq_st.skip_first) begin
                        seq_st.skip_first = 1'b0;
                     end else begin
                        res.quarter_frame = 1'b1;
                        res.half_frame    = 1'b1;
                     end
                  end
                  CNT_STEP1: res.quarter_frame = 1'b1;
                  CNT_STEP2: begin
                     res.quarter_frame = 1'b1;
                     res.half_frame    = 1'b1;
                  end
                  CNT_STEP3: res.quarter_frame = 1'b1;
                  CNT_WRAP5: begin
                     res.quarter_frame = 1'b1;
                     res.half_frame    = 1'b1;
                     seq_st.count      = CNT_FIRST5;
                  end
                  default: ;
               endcase
            end
            if (irq_hit && !seq_st.inhibit) seq_st.irq_flag = 1'b1;
            seq_st.count = seq_st.count + 16'd1;
         end
         KIND_WRITE: begin
            if (it.reg_offset == OFS_STATUS) begin
               res.enable_update   = 1'b1;
               res.channel_enables = it.write_data[4:0];
            end else if (it.reg_offset == OFS_FRAME) begin
               seq_st.five_step = it.write_data[MODE_BIT];
               if (seq_st.five_step) begin
                  // five-step write clocks both units right away
                  res.quarter_frame = 1'b1;
                  res.half_frame    = 1'b1;
                  seq_st.skip_first = 1'b1;
               end
               seq_st.inhibit = it.write_data[INHIBIT_BIT];
               if (seq_st.inhibit) seq_st.irq_flag = 1'b0;
               seq_st.delay = seq_st.odd ? DELAY_WAIT : DELAY_NOW;
               seq_st.count = '0;
            end
         end
         KIND_READ: begin
            if (it.reg_offset == OFS_STATUS) begin
               res.read_data = {it.dmc_irq, seq_st.irq_flag, 1'b0, it.channel_active};
               seq_st.irq_flag = 1'b0;
            end
         end
         default: ;
      endcase
      res.frame_irq = seq_st.irq_flag;
      return res;
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   task automatic queue_item(input logic [1:0] k, input logic [4:0] ofs,
                             input logic [7:0] wd, input logic [4:0] act,
                             input logic dirq);
      req_item_type it;
      it.kind           = k;
      it.reg_offset     = ofs;
      it.write_data     = wd;
      it.channel_active = act;
      it.dmc_irq        = dirq;
      pending_q.push_back(it);
   endtask

   // random mix of ticks, writes, reads and spare kinds
   task automatic queue_noise();
      int         pick;
      logic [1:0] k;
      logic [4:0] ofs;
      pick = $urandom_range(0, 99);
      ofs  = 5'($urandom_range(0, 31));
      if (pick < 40) begin
         k = KIND_TICK;
      end else if (pick < 65) begin
         k = KIND_WRITE;
         if (pick < 50) ofs = OFS_FRAME;
         else if (pick < 58) ofs = OFS_STATUS;
      end else if (pick < 90) begin
         k = KIND_READ;
         if (pick < 82) ofs = OFS_STATUS;
      end else begin
         k = KIND_SPARE;
      end
      queue_item(k, ofs, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                 1'($urandom_range(0, 1)));
   endtask

   task automatic check_field(input string fname, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, fname, want, got);
         mismatch_count++;
      end
   endtask

   // ------------------------------------------------------------------
   // clock
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // driver: presents queued requests at the falling edge, with random gaps
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset) begin
         if (drv_hold && req_taken) drv_hold = 1'b0;
         if (!drv_hold) begin
            if (!drv_pending && pending_q.size() != 0) begin
               drv_item    = pending_q.pop_front();
               drv_gap     = $urandom_range(0, MAX_WAIT);
               drv_pending = 1'b1;
            end
            if (drv_pending && drv_gap == 0) begin
               req_ch.kind           <= drv_item.kind;
               req_ch.reg_offset     <= drv_item.reg_offset;
               req_ch.write_data     <= drv_item.write_data;
               req_ch.channel_active <= drv_item.channel_active;
               req_ch.dmc_irq        <= drv_item.dmc_irq;
               req_ch.valid          <= 1'b1;
               drv_hold    = 1'b1;
               drv_pending = 1'b0;
            end else begin
               req_ch.valid <= 1'b0;
               if (drv_pending) drv_gap--;
            end
         end
      end
   end

   // response side back-pressure: a random stall after every transfer
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) rsp_wait = $urandom_range(0, MAX_WAIT);
         if (rsp_wait > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_wait--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // monitor: checks each response transfer, then predicts each request transfer
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      frame_result_type want;
      req_item_type     seen;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         rsp_taken <= rsp_ch.valid && rsp_ch.ready;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (frame_exp_q.size() == 0) begin
               $display({"%0t ns: response with none expected, ",
                         "actual qf %b hf %b irq %b rd %h upd %b en %h"},
                        $time, rsp_ch.quarter_frame, rsp_ch.half_frame, rsp_ch.frame_irq,
                        rsp_ch.read_data, rsp_ch.enable_update, rsp_ch.channel_enables);
               mismatch_count++;
            end else begin
               want = frame_exp_q.pop_front();
               check_field("quarter_frame", 8'(want.quarter_frame),
                           8'(rsp_ch.quarter_frame));
               check_field("half_frame", 8'(want.half_frame), 8'(rsp_ch.half_frame));
               check_field("frame_irq", 8'(want.frame_irq), 8'(rsp_ch.frame_irq));
               check_field("read_data", want.read_data, rsp_ch.read_data);
               check_field("enable_update", 8'(want.enable_update),
                           8'(rsp_ch.enable_update));
               check_field("channel_enables", 8'(want.channel_enables),
                           8'(rsp_ch.channel_enables));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            seen.kind           = req_ch.kind;
            seen.reg_offset     = req_ch.reg_offset;
            seen.write_data     = req_ch.write_data;
            seen.channel_active = req_ch.channel_active;
            seen.dmc_irq        = req_ch.dmc_irq;
            frame_exp_q.push_back(frame_step(seen));
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      // known values on every input from time zero
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.kind           = KIND_TICK;
      req_ch.reg_offset     = '0;
      req_ch.write_data     = '0;
      req_ch.channel_active = '0;
      req_ch.dmc_irq        = 1'b0;
      rsp_ch.ready          = 1'b0;
      mismatch_count        = 0;
      rsp_wait              = 0;
      drv_pending           = 1'b0;
      drv_hold              = 1'b0;
      drv_gap               = 0;

      // predictor starts from the reset state
      seq_st.count      = CNT_RESET;
      seq_st.five_step  = 1'b0;
      seq_st.inhibit    = 1'b0;
      seq_st.irq_flag   = 1'b0;
      seq_st.odd        = 1'b0;
      seq_st.delay      = DELAY_IDLE;
      seq_st.skip_first = 1'b0;

      // directed: status port, ignored offsets and the spare kind, no frame write yet
      queue_item(KIND_TICK,  5'h00,      8'h00, 5'h00, 1'b0);
      queue_item(KIND_WRITE, OFS_STATUS, 8'hFF, 5'h1F, 1'b1);
      queue_item(KIND_WRITE, OFS_STATUS, 8'hE0, 5'h00, 1'b0);
      queue_item(KIND_READ,  OFS_STATUS, 8'h00, 5'h1F, 1'b1);
      queue_item(KIND_READ,  OFS_STATUS, 8'hFF, 5'h00, 1'b0);
      queue_item(KIND_READ,  5'h00,      8'h00, 5'h1F, 1'b1);
      queue_item(KIND_WRITE, 5'h1F,      8'hFF, 5'h1F, 1'b1);
      queue_item(KIND_SPARE, 5'h1F,      8'hFF, 5'h1F, 1'b1);
      queue_item(KIND_READ,  OFS_FRAME,  8'hFF, 5'h1F, 1'b1);
      queue_item(KIND_TICK,  5'h1F,      8'hFF, 5'h1F, 1'b1);

      // directed: every mode and inhibit combination, odd and even parity
      queue_item(KIND_WRITE, OFS_FRAME,  8'h00, 5'h00, 1'b0);
      queue_item(KIND_TICK,  5'h00,      8'h00, 5'h00, 1'b0);
      queue_item(KIND_WRITE, OFS_FRAME,  8'h40, 5'h00, 1'b0);
      queue_item(KIND_TICK,  5'h00,      8'h00, 5'h00, 1'b0);
      queue_item(KIND_TICK,  5'h00,      8'h00, 5'h00, 1'b0);
      queue_item(KIND_WRITE, OFS_FRAME,  8'h80, 5'h00, 1'b0);
      queue_item(KIND_TICK,  5'h00,      8'h00, 5'h00, 1'b0);
      queue_item(KIND_TICK,  5'h00,      8'h00, 5'h00, 1'b0);
      queue_item(KIND_TICK,  5'h00,      8'h00, 5'h00, 1'b0);
      queue_item(KIND_WRITE, OFS_FRAME,  8'hC0, 5'h00, 1'b0);
      queue_item(KIND_TICK,  5'h00,      8'h00, 5'h00, 1'b0);
      queue_item(KIND_WRITE, OFS_FRAME,  8'hFF, 5'h00, 1'b0);
      queue_item(KIND_WRITE, OFS_FRAME,  8'h3F, 5'h00, 1'b0);
      queue_item(KIND_READ,  OFS_STATUS, 8'h00, 5'h15, 1'b1);
      queue_item(KIND_TICK,  5'h00,      8'h00, 5'h00, 1'b0);

      // random mix for the rest of the run
      repeat (1475) queue_noise();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // every request sent, then every response back, then a short drain
      while (pending_q.size() != 0 || drv_pending || drv_hold) @(posedge clock);
      while (frame_exp_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // hang guard, well above the slowest legal run
   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
